// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check an implication on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/rti_pkg.sv -----
package rti_pkg;

    // Default geometry of the coordinates
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Field widths on the streams
    localparam int FIELD_W = 32;
    localparam int DIST_W  = 32;
    localparam int QBITS   = DIST_W - 1;

    localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // Request kinds carried in tuser
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } t_req;

    // Flags that travel beside the divider data
    typedef struct packed {
        logic hit;
        logic neg;
        logic sat;
    } t_side;

endpackage

// ----- rtl/core/rti_cross.sv -----
module rti_cross #(
    parameter int DW   = 33,
    parameter int FRAC = 16,
    parameter int XW   = 51
) (
    input  logic                 i_clk,
    input  logic                 i_en_prod,
    input  logic                 i_en_res,
    input  logic signed [DW-1:0] i_a [0:2],
    input  logic signed [DW-1:0] i_b [0:2],
    output logic signed [XW-1:0] o_c [0:2]
);

    localparam int PW = 2 * DW;
    localparam int TW = PW + 1;

    logic signed [PW-1:0] r_p [0:5];
    logic signed [TW-1:0] w_raw [0:2];
    logic signed [TW-1:0] w_sh [0:2];
    logic signed [XW-1:0] n_c [0:2];
    logic signed [XW-1:0] r_c [0:2];

    // Register the six partial products
    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            r_p[0] <= i_a[1] * i_b[2];
            r_p[1] <= i_a[2] * i_b[1];
            r_p[2] <= i_a[2] * i_b[0];
            r_p[3] <= i_a[0] * i_b[2];
            r_p[4] <= i_a[0] * i_b[1];
            r_p[5] <= i_a[1] * i_b[0];
        end
    end

    // Subtract, floor shift and saturate to XW bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_raw[k] = TW'(r_p[2*k]) - TW'(r_p[2*k+1]);
            w_sh[k]  = w_raw[k] >>> FRAC;
            if ((&w_sh[k][TW-1:XW-1]) || !(|w_sh[k][TW-1:XW-1])) begin
                n_c[k] = w_sh[k][XW-1:0];
            end else if (w_sh[k][TW-1]) begin
                n_c[k] = {1'b1, {(XW-1){1'b0}}};
            end else begin
                n_c[k] = {1'b0, {(XW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_res) begin
            r_c <= n_c;
        end
    end

    assign o_c = r_c;

endmodule

// ----- rtl/core/rti_dot.sv -----
module rti_dot #(
    parameter int DW = 33,
    parameter int XW = 51
) (
    input  logic                         i_clk,
    input  logic                         i_en_prod,
    input  logic                         i_en_sum,
    input  logic signed [DW-1:0]         i_a [0:2],
    input  logic signed [XW-1:0]         i_b [0:2],
    output logic signed [DW+XW+1:0]      o_dot
);

    localparam int LO  = XW / 2;
    localparam int HI  = XW - LO;
    localparam int DPW = DW + XW + 2;

    logic signed [DW+LO:0]   r_lo [0:2];
    logic signed [DW+HI-1:0] r_hi [0:2];
    logic signed [DPW-1:0]   n_sum;
    logic signed [DPW-1:0]   r_sum;

    // Split each product into a low and a high half
    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= i_a[i] * $signed({1'b0, i_b[i][LO-1:0]});
                r_hi[i] <= i_a[i] * $signed(i_b[i][XW-1:LO]);
            end
        end
    end

    // Recombine the halves and add the three terms
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 3; i++) begin
            n_sum = n_sum + DPW'(r_lo[i]) + (DPW'(r_hi[i]) <<< LO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_dot = r_sum;

endmodule

// ----- rtl/core/rti_div_step.sv -----
module rti_div_step import rti_pkg::*; #(
    parameter int DPW = 101,
    parameter int RW  = 149,
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [RW-1:0]    i_rem,
    input  logic [DPW-1:0]   i_den,
    input  logic [QBITS-1:0] i_q,
    input  t_side            i_side,
    output logic [RW-1:0]    o_rem,
    output logic [DPW-1:0]   o_den,
    output logic [QBITS-1:0] o_q,
    output t_side            o_side
);

    logic [RW-1:0]    w_sub;
    logic             w_ge;
    logic [QBITS-1:0] n_q;
    logic [RW-1:0]    n_rem;
    logic [RW-1:0]    r_rem;
    logic [DPW-1:0]   r_den;
    logic [QBITS-1:0] r_q;
    t_side            r_side;

    // Try the shifted divisor and set one quotient bit
    always_comb begin
        w_sub    = RW'(i_den) << IDX;
        w_ge     = i_rem >= w_sub;
        n_rem    = w_ge ? (i_rem - w_sub) : i_rem;
        n_q      = i_q;
        n_q[IDX] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

// ----- rtl/core/ray_triangle_intersect.sv -----
// Ray / triangle intersection test, signed fixed point.
// Input stream (s side): tuser[0] selects the request. A load item
// (tuser 0) stores vec0 as the ray origin and vec1 as the direction and
// gives no result. A test item (tuser 1) carries triangle vertices
// vec0, vec1, vec2 and gives one result item.
// Output stream (m side): tuser[0] is the hit flag, tdata the distance t
// (truncated, saturated to 32 bits, zero on a miss).
// Throughput: one item per cycle, load or test, in any mix, while the
// receiver does not stall. The datapath is a 40-stage pipeline: two
// cross-product stages, two dot-product stages, three compare/prepare
// stages and one stage per quotient bit (31) in the restoring divider,
// plus input and output registers.
// Reset clears the stored ray to zero and empties the pipeline; a test
// before any load is a miss.
// When the receiver stalls, results pile up in the stages; tready on the
// input drops only once every stage is full, so no item is lost.
`include "assert_macros.svh"

module ray_triangle_intersect import rti_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // vec0_x, vec0_y, vec0_z, vec1_x, vec1_y, vec1_z, vec2_x, vec2_y, vec2_z
    input  logic [9*FIELD_W-1:0] i_s_tdata,
    // req_type
    input  logic [0:0]           i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // distance
    output logic [DIST_W-1:0]    o_m_tdata,
    // hit
    output logic [0:0]           o_m_tuser
);

    localparam int CW        = COORD_WIDTH;
    localparam int DW        = CW + 1;
    localparam int TW        = 2 * DW + 1;
    localparam int SW        = TW - FRAC_BITS;
    localparam int XW        = (SW > 64) ? 64 : SW;
    localparam int DPW       = DW + XW + 2;
    localparam int RW        = DPW + FRAC_BITS + 32;
    localparam int DIV_FIRST = 9;
    localparam int NS        = DIV_FIRST + QBITS;

    // Handshake chain
    logic [NS:1] r_v;
    logic [NS:1] w_en;
    logic        w_accept;
    logic        w_in_test;

    // Input coordinates and stored ray
    logic [CW+FIELD_W-1:0] w_ext   [0:8];
    logic signed [CW-1:0]  w_coord [0:8];
    logic signed [CW-1:0]  r_org   [0:2];
    logic signed [CW-1:0]  r_dir   [0:2];

    // Edge vectors through the cross-product stages
    logic signed [DW-1:0] r1_e1 [0:2];
    logic signed [DW-1:0] r1_e2 [0:2];
    logic signed [DW-1:0] r1_s  [0:2];
    logic signed [DW-1:0] r1_d  [0:2];
    logic signed [DW-1:0] r2_e1 [0:2];
    logic signed [DW-1:0] r2_e2 [0:2];
    logic signed [DW-1:0] r2_s  [0:2];
    logic signed [DW-1:0] r2_d  [0:2];
    logic signed [DW-1:0] r3_e1 [0:2];
    logic signed [DW-1:0] r3_e2 [0:2];
    logic signed [DW-1:0] r3_s  [0:2];
    logic signed [DW-1:0] r3_d  [0:2];
    logic signed [XW-1:0] w_h   [0:2];
    logic signed [XW-1:0] w_q   [0:2];

    // Dot products and compare stages
    logic signed [DPW-1:0] w_det;
    logic signed [DPW-1:0] w_un;
    logic signed [DPW-1:0] w_vn;
    logic signed [DPW-1:0] w_tn;
    logic signed [DPW-1:0] r6_det;
    logic signed [DPW-1:0] r6_un;
    logic signed [DPW-1:0] r6_vn;
    logic signed [DPW-1:0] r6_tn;
    logic                  r6_zero;
    logic signed [DPW:0]   w_uv;
    logic signed [DPW:0]   w_det_x;
    logic                  w_miss;
    logic                  r7_hit;
    logic                  r7_neg;
    logic [DPW-1:0]        r7_mag;
    logic [DPW-1:0]        r7_den;
    logic [RW-1:0]         w_num;
    logic [RW-1:0]         w_lim;

    // Divider chain
    logic [RW-1:0]    w_rem  [0:QBITS];
    logic [DPW-1:0]   w_den  [0:QBITS];
    logic [QBITS-1:0] w_qv   [0:QBITS];
    t_side            w_side [0:QBITS];
    logic [RW-1:0]    r8_rem;
    logic [DPW-1:0]   r8_den;
    t_side            r8_side;

    // Output register
    logic [DIST_W-1:0] w_qx;
    logic [DIST_W-1:0] n_dist;
    logic [DIST_W-1:0] r_dist;
    logic              r_hit;

    // Each stage loads when empty or when the next one moves on
    always_comb begin
        w_en[NS] = !r_v[NS] || i_m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_s_tready = w_en[1];
    assign w_accept   = i_s_tvalid && w_en[1];
    assign w_in_test  = i_s_tvalid && (i_s_tuser[0] == REQ_TEST);

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= w_in_test;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Take the low coordinate bits, sign extended
    for (genvar g = 0; g < 9; g++) begin : g_coord
        assign w_ext[g]   = {{CW{i_s_tdata[FIELD_W*g+FIELD_W-1]}},
                             i_s_tdata[FIELD_W*g +: FIELD_W]};
        assign w_coord[g] = w_ext[g][CW-1:0];
    end

    // Replace the ray on a load item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
                r_dir[i] <= '0;
            end
        end else if (w_accept && (i_s_tuser[0] == REQ_LOAD)) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= w_coord[i];
                r_dir[i] <= w_coord[3+i];
            end
        end
    end

    // Form edges and carry them past the cross products
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r1_e1[i] <= DW'(w_coord[3+i]) - DW'(w_coord[i]);
                r1_e2[i] <= DW'(w_coord[6+i]) - DW'(w_coord[i]);
                r1_s[i]  <= DW'(r_org[i]) - DW'(w_coord[i]);
                r1_d[i]  <= DW'(r_dir[i]);
            end
        end
        if (w_en[2]) begin
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_s  <= r1_s;
            r2_d  <= r1_d;
        end
        if (w_en[3]) begin
            r3_e1 <= r2_e1;
            r3_e2 <= r2_e2;
            r3_s  <= r2_s;
            r3_d  <= r2_d;
        end
    end

    rti_cross #(.DW(DW), .FRAC(FRAC_BITS), .XW(XW)) u_cross_h (
        .i_clk     (i_clk),
        .i_en_prod (w_en[2]),
        .i_en_res  (w_en[3]),
        .i_a       (r1_d),
        .i_b       (r1_e2),
        .o_c       (w_h)
    );

    rti_cross #(.DW(DW), .FRAC(FRAC_BITS), .XW(XW)) u_cross_q (
        .i_clk     (i_clk),
        .i_en_prod (w_en[2]),
        .i_en_res  (w_en[3]),
        .i_a       (r1_s),
        .i_b       (r1_e1),
        .o_c       (w_q)
    );

    rti_dot #(.DW(DW), .XW(XW)) u_dot_det (
        .i_clk(i_clk), .i_en_prod(w_en[4]), .i_en_sum(w_en[5]),
        .i_a(r3_e1), .i_b(w_h), .o_dot(w_det)
    );

    rti_dot #(.DW(DW), .XW(XW)) u_dot_u (
        .i_clk(i_clk), .i_en_prod(w_en[4]), .i_en_sum(w_en[5]),
        .i_a(r3_s), .i_b(w_h), .o_dot(w_un)
    );

    rti_dot #(.DW(DW), .XW(XW)) u_dot_v (
        .i_clk(i_clk), .i_en_prod(w_en[4]), .i_en_sum(w_en[5]),
        .i_a(r3_d), .i_b(w_q), .o_dot(w_vn)
    );

    rti_dot #(.DW(DW), .XW(XW)) u_dot_t (
        .i_clk(i_clk), .i_en_prod(w_en[4]), .i_en_sum(w_en[5]),
        .i_a(r3_e2), .i_b(w_q), .o_dot(w_tn)
    );

    // Flag a zero determinant and make it non-negative, negating u, v and t with it
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_zero <= (w_det == '0);
            if (w_det[DPW-1]) begin
                r6_det <= -w_det;
                r6_un  <= -w_un;
                r6_vn  <= -w_vn;
                r6_tn  <= -w_tn;
            end else begin
                r6_det <= w_det;
                r6_un  <= w_un;
                r6_vn  <= w_vn;
                r6_tn  <= w_tn;
            end
        end
    end

    // Test barycentric bounds and take the magnitude of t
    always_comb begin
        w_uv    = (DPW+1)'(r6_un) + (DPW+1)'(r6_vn);
        w_det_x = (DPW+1)'(r6_det);
        w_miss  = r6_zero || r6_un[DPW-1] || (r6_un > r6_det) ||
                  r6_vn[DPW-1] || (w_uv > w_det_x);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_hit <= !w_miss;
            r7_neg <= r6_tn[DPW-1];
            r7_mag <= r6_tn[DPW-1] ? -r6_tn : r6_tn;
            r7_den <= r6_det;
        end
    end

    // Scale the numerator and flag a quotient beyond 31 bits
    always_comb begin
        w_num = RW'(r7_mag) << FRAC_BITS;
        w_lim = RW'(r7_den) << QBITS;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r8_rem       <= w_num;
            r8_den       <= r7_den;
            r8_side.hit  <= r7_hit;
            r8_side.neg  <= r7_neg;
            r8_side.sat  <= (w_num >= w_lim);
        end
    end

    assign w_rem[0]  = r8_rem;
    assign w_den[0]  = r8_den;
    assign w_qv[0]   = '0;
    assign w_side[0] = r8_side;

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < QBITS; j++) begin : g_div
        rti_div_step #(.DPW(DPW), .RW(RW), .IDX(QBITS - 1 - j)) u_step (
            .i_clk  (i_clk),
            .i_en   (w_en[DIV_FIRST+j]),
            .i_rem  (w_rem[j]),
            .i_den  (w_den[j]),
            .i_q    (w_qv[j]),
            .i_side (w_side[j]),
            .o_rem  (w_rem[j+1]),
            .o_den  (w_den[j+1]),
            .o_q    (w_qv[j+1]),
            .o_side (w_side[j+1])
        );
    end

    // Apply sign and saturation, zero on a miss
    always_comb begin
        w_qx = {1'b0, w_qv[QBITS]};
        if (!w_side[QBITS].hit) begin
            n_dist = '0;
        end else if (w_side[QBITS].sat) begin
            n_dist = w_side[QBITS].neg ? DIST_MIN : DIST_MAX;
        end else if (w_side[QBITS].neg) begin
            n_dist = ~w_qx + 1'b1;
        end else begin
            n_dist = w_qx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS]) begin
            r_dist <= n_dist;
            r_hit  <= w_side[QBITS].hit;
        end
    end

    assign o_m_tvalid   = r_v[NS];
    assign o_m_tdata    = r_dist;
    assign o_m_tuser[0] = r_hit;

    `ASSERT_CLK(a_load_no_result, (w_accept && (i_s_tuser[0] == REQ_LOAD)) |=> !r_v[1], "load item entered pipeline")
    `ASSERT_CLK(a_miss_zero, (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0), "miss with nonzero distance")
    `ASSERT_CLK(a_stall_full, !o_s_tready |-> r_v[1], "input stalled with empty first stage")
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

// ----- sim/ray_triangle_intersect_tb.sv -----
`timescale 1ns / 100ps

module ray_triangle_intersect_tb import rti_pkg::*;;

    localparam int N_RANDOM = 1520;

    // Predictor of hit flag and distance, with the queue of expected results
    class intersect_scoreboard;
        typedef struct {
            logic        hit;
            logic [31:0] distance;
        } hit_rec;

        logic signed [63:0] org[3];
        logic signed [63:0] dir[3];
        hit_rec             pending[$];
        int                 mismatches;
        int                 tests;
        int                 hits;
        int                 loads;

        function new();
            for (int i = 0; i < 3; i++) begin
                org[i] = '0;
                dir[i] = '0;
            end
            mismatches = 0;
            tests      = 0;
            hits       = 0;
            loads      = 0;
        endfunction

        // a1*b2 - a2*b1, floor shift by the fraction, clamp to 64 bits
        function logic signed [63:0] cross_term(logic signed [63:0] a1, logic signed [63:0] b2,
                                                logic signed [63:0] a2, logic signed [63:0] b1);
            logic signed [127:0] wa1, wb2, wa2, wb1, diff, top, bot;
            wa1  = a1;
            wb2  = b2;
            wa2  = a2;
            wb1  = b1;
            diff = (wa1 * wb2 - wa2 * wb1) >>> FRAC_BITS_DEF;
            top  = {64'd0, 64'h7FFF_FFFF_FFFF_FFFF};
            bot  = {{64{1'b1}}, 64'h8000_0000_0000_0000};
            if (diff > top) return top[63:0];
            if (diff < bot) return bot[63:0];
            return diff[63:0];
        endfunction

        function logic signed [127:0] dot3(logic signed [63:0] a[3], logic signed [63:0] b[3]);
            logic signed [127:0] acc, wa, wb;
            acc = '0;
            for (int i = 0; i < 3; i++) begin
                wa  = a[i];
                wb  = b[i];
                acc = acc + wa * wb;
            end
            return acc;
        endfunction

        // Note an accepted input item and queue its expected result
        function void note_item(logic req, logic [9*FIELD_W-1:0] data);
            logic signed [63:0]  va[3], vb[3], vc[3], e1[3], e2[3], s[3], h[3], q[3];
            logic signed [127:0] det, un, vn, tn;
            logic [127:0]        mag;
            logic [159:0]        quo;
            hit_rec              r;
            for (int i = 0; i < 3; i++) begin
                va[i] = $signed(data[i*32 +: 32]);
                vb[i] = $signed(data[(3+i)*32 +: 32]);
                vc[i] = $signed(data[(6+i)*32 +: 32]);
            end
            if (req == REQ_LOAD) begin
                org   = va;
                dir   = vb;
                loads++;
                return;
            end
            tests++;
            for (int i = 0; i < 3; i++) begin
                e1[i] = vb[i] - va[i];
                e2[i] = vc[i] - va[i];
                s[i]  = org[i] - va[i];
            end
            h[0] = cross_term(dir[1], e2[2], dir[2], e2[1]);
            h[1] = cross_term(dir[2], e2[0], dir[0], e2[2]);
            h[2] = cross_term(dir[0], e2[1], dir[1], e2[0]);
            q[0] = cross_term(s[1], e1[2], s[2], e1[1]);
            q[1] = cross_term(s[2], e1[0], s[0], e1[2]);
            q[2] = cross_term(s[0], e1[1], s[1], e1[0]);
            det  = dot3(e1, h);
            un   = dot3(s, h);
            vn   = dot3(dir, q);
            tn   = dot3(e2, q);
            r.hit      = 1'b0;
            r.distance = '0;
            if (det != 0) begin
                if (det < 0) begin
                    det = -det;
                    un  = -un;
                    vn  = -vn;
                    tn  = -tn;
                end
                if (!(un < 0 || un > det || vn < 0 || un + vn > det)) begin
                    r.hit = 1'b1;
                    mag   = (tn < 0) ? -tn : tn;
                    quo   = {16'd0, mag, 16'd0} / {32'd0, det};
                    if (tn < 0)
                        r.distance = (quo >= 160'h8000_0000) ? DIST_MIN : -quo[31:0];
                    else
                        r.distance = (quo >= 160'h8000_0000) ? DIST_MAX : quo[31:0];
                    hits++;
                end
            end
            pending.push_back(r);
        endfunction

        // Check one result against the oldest expectation
        function void check_result(logic hit, logic [31:0] distance);
            hit_rec r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit %0b distance %h", hit, distance);
                return;
            end
            r = pending.pop_front();
            if (r.hit !== hit || r.distance !== distance) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected hit %0b distance %h, got hit %0b distance %h",
                             r.hit, r.distance, hit, distance);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [9*FIELD_W-1:0] i_s_tdata = '0;
    logic [0:0]           i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [DIST_W-1:0]    o_m_tdata;
    logic [0:0]           o_m_tuser;

    intersect_scoreboard sb = new();
    bit                  calm = 1'b0;
    bit                  hold_off = 1'b0;
    int                  sent = 0;
    int                  cur_o[3];
    int                  cur_d[3];

    ray_triangle_intersect u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_item(i_s_tuser[0], i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser[0], o_m_tdata);
    end

    // Receiver: random stall bursts, or a long hold-off when asked
    initial begin : receiver
        int idle_left;
        idle_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_m_tready = 1'b0;
            end else if (idle_left > 0) begin
                i_m_tready = 1'b0;
                idle_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_m_tready = 1'b0;
                idle_left  = $urandom_range(1, 6) - 1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // Long stall of the receiver so the pipeline fills and blocks the input
    initial begin : pressure
        wait (sent >= 300);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Give up after a generous time
    initial begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one item and hold it until accepted; call at a falling edge
    task automatic send_item(logic req, int f[9]);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        for (int i = 0; i < 9; i++)
            i_s_tdata[i*32 +: 32] = f[i];
        i_s_tuser  = req;
        i_s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic load_ray(int o[3], int d[3]);
        int f[9];
        for (int i = 0; i < 3; i++) begin
            f[i]     = o[i];
            f[3+i]   = d[i];
            f[6+i]   = $urandom;
            cur_o[i] = o[i];
            cur_d[i] = d[i];
        end
        send_item(REQ_LOAD, f);
    endtask

    task automatic test_tri(int a[3], int b[3], int c[3]);
        int f[9];
        for (int i = 0; i < 3; i++) begin
            f[i]   = a[i];
            f[3+i] = b[i];
            f[6+i] = c[i];
        end
        send_item(REQ_TEST, f);
    endtask

    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Triangle laid around the point where the current ray is at some t
    task automatic aimed_tri();
        int     a[3], b[3], c[3], p[3], r;
        longint t;
        t = srand(1 << 19);
        r = $urandom_range(1 << 10, 1 << 17);
        for (int i = 0; i < 3; i++)
            p[i] = cur_o[i] + int'((longint'(cur_d[i]) * t) >>> 16);
        a = '{p[0] - r + srand(r / 4), p[1] - r + srand(r / 4), p[2] + srand(r)};
        b = '{p[0] + 2 * r + srand(r / 4), p[1] - r, p[2] + srand(r)};
        c = '{p[0] - r, p[1] + 2 * r + srand(r / 4), p[2] + srand(r)};
        if ($urandom_range(0, 1)) test_tri(a, c, b);
        else test_tri(a, b, c);
    endtask

    task automatic random_item();
        int a[3], b[3], c[3];
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            if ($urandom_range(0, 3) == 0) begin
                a = '{$urandom, $urandom, $urandom};
                b = '{$urandom, $urandom, $urandom};
            end else begin
                a = '{srand(1 << 18), srand(1 << 18), srand(1 << 18)};
                b = '{srand(1 << 15), srand(1 << 15), $urandom_range(1 << 15, 1 << 17)};
                if ($urandom_range(0, 3) == 0) b[2] = -b[2];
            end
            load_ray(a, b);
        end else if (pick < 57) begin
            aimed_tri();
        end else if (pick < 77) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = srand(1 << 19);
                b[i] = srand(1 << 19);
                c[i] = srand(1 << 19);
            end
            test_tri(a, b, c);
        end else if (pick < 87) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = $urandom;
                b[i] = $urandom;
                c[i] = $urandom;
            end
            test_tri(a, b, c);
        end else if (pick < 95) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = srand(16);
                b[i] = srand(16);
                c[i] = srand(16);
            end
            test_tri(a, b, c);
        end else begin
            // degenerate: repeated vertex or collinear points
            for (int i = 0; i < 3; i++) begin
                a[i] = srand(1 << 18);
                b[i] = srand(1 << 18);
                c[i] = 2 * b[i] - a[i];
            end
            if ($urandom_range(0, 1)) c = a;
            test_tri(a, b, c);
        end
    endtask

    localparam int ONE = 32'h0001_0000;

    // Stimulus
    initial begin : sender
        int zo[3], zd[3], mx[3], mn[3];
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // test before any ray is loaded
        test_tri('{0, 0, 5 * ONE}, '{ONE, 0, 5 * ONE}, '{0, ONE, 5 * ONE});
        // ray along z through the origin
        zo = '{0, 0, 0};
        zd = '{0, 0, ONE};
        load_ray(zo, zd);
        // through vertex A: u and v both exactly zero
        test_tri('{0, 0, 5 * ONE}, '{ONE, 0, 5 * ONE}, '{0, ONE, 5 * ONE});
        // through vertex B: u exactly one
        test_tri('{-ONE, 0, 3 * ONE}, '{0, 0, 3 * ONE}, '{-ONE, ONE, 3 * ONE});
        // on edge BC: u + v exactly one
        test_tri('{-ONE, -ONE, 2 * ONE}, '{ONE, -ONE, 2 * ONE}, '{-ONE, ONE, 2 * ONE});
        // opposite winding, negative determinant
        test_tri('{-ONE, -ONE, 2 * ONE}, '{-ONE, 2 * ONE, 2 * ONE}, '{2 * ONE, -ONE, 2 * ONE});
        // behind the origin: negative distance
        test_tri('{-ONE, -ONE, -4 * ONE}, '{2 * ONE, -ONE, -4 * ONE}, '{-ONE, 2 * ONE, -4 * ONE});
        // just outside: u below zero, v below zero, u + v above one
        test_tri('{1, 0, ONE}, '{ONE, 0, ONE}, '{1, ONE, ONE});
        test_tri('{0, 1, ONE}, '{ONE, 1, ONE}, '{0, ONE, ONE});
        test_tri('{-ONE, -ONE, ONE}, '{ONE - 1, -ONE, ONE}, '{-ONE, ONE - 1, ONE});
        // triangle parallel to the ray: zero determinant
        test_tri('{0, -ONE, 0}, '{0, ONE, ONE}, '{0, 0, 2 * ONE});
        // tiny direction, far triangle: saturated distance both ways
        zd = '{0, 0, 1};
        load_ray(zo, zd);
        test_tri('{-ONE, -ONE, 30000 * ONE}, '{2 * ONE, -ONE, 30000 * ONE},
                 '{-ONE, 2 * ONE, 30000 * ONE});
        test_tri('{-ONE, -ONE, -30000 * ONE}, '{2 * ONE, -ONE, -30000 * ONE},
                 '{-ONE, 2 * ONE, -30000 * ONE});
        // extremes of the coordinates
        mx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        load_ray(mn, mx);
        test_tri(mx, mn, '{32'h7FFF_FFFF, 32'h8000_0000, 0});
        test_tri(mn, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, mx);
        load_ray(mx, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        test_tri(mn, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                 '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        test_tri('{-1, -1, -1}, '{0, 0, 0}, mx);
        // back to a sensible ray for the random part
        load_ray('{ONE, -ONE, -8 * ONE}, '{ONE / 8, -ONE / 16, ONE});

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 150) calm = 1'b1;
            random_item();
        end
        i_s_tvalid = 1'b0;

        wait (sb.pending.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("covered %0d ray loads and %0d triangle tests, %0d of them hits",
                 sb.loads, sb.tests, sb.hits);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatching results", sb.mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
